// ----- rtl/ipv4_fragment_reassembly_tracker_top_assert.svh -----
// Assertion macros for the fragment reassembly tracker.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef IPV4_FRAGMENT_REASSEMBLY_TRACKER_TOP_ASSERT_SVH
`define IPV4_FRAGMENT_REASSEMBLY_TRACKER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define FRT_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

`define FRT_ASSERT_IMPLY(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

`else

`define FRT_ASSERT_ALWAYS(lbl, expr, msg)

`define FRT_ASSERT_IMPLY(lbl, pre, post, msg)

`endif

`endif

// ----- rtl/frt_pkg.sv -----
`timescale 1ns / 1ps
package frt_pkg;

	localparam int CTX_N   = 8;
	localparam int CTX_W   = $clog2(CTX_N);
	localparam int RANGE_N = 16;
	localparam int RANGE_W = $clog2(RANGE_N);
	localparam int CNT_W   = RANGE_W + 1;
	localparam int MEM_W   = CTX_W + RANGE_W;
	localparam int MEM_N   = CTX_N * RANGE_N;

	typedef enum logic [2:0] {
		ST_STORED   = 3'd0,
		ST_COMPLETE = 3'd1,
		ST_BAD      = 3'd2,
		ST_TOO_BIG  = 3'd3,
		ST_CONFLICT = 3'd4,
		ST_TIMEOUT  = 3'd5
	} status_t;

	typedef enum logic {
		ACT_FRAG = 1'b0,
		ACT_TICK = 1'b1
	} action_t;

	typedef enum logic {
		REG_MAX_PAYLOAD = 1'b0,
		REG_TIMEOUT     = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ROW_HOLD,
		ROW_CLEAR,
		ROW_LOAD,
		ROW_STORE,
		ROW_INSERT,
		ROW_MERGE
	} row_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FRAG,
		S_EVICT,
		S_LIMIT,
		S_LOAD,
		S_INSERT,
		S_MERGE,
		S_STORE,
		S_EMIT,
		S_TSCAN,
		S_TNEXT,
		S_TEMIT
	} fsm_t;

	typedef struct packed {
		row_op_t     op;
		logic [15:0] lo;
		logic [15:0] hi;
	} row_cmd_t;

	typedef struct packed {
		logic        v;
		logic [15:0] st;
		logic [15:0] en;
	} range_t;

	typedef struct packed {
		logic        action;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] ident;
		logic [7:0]  protocol;
		logic [12:0] frag_offset;
		logic        more_frags;
		logic [15:0] payload_len;
		logic        has_header_zero;
		logic [47:0] now_ms;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [2:0]  slot;
		logic [15:0] reasm_len;
		logic        evicted;
		logic        send_time_exceeded;
		logic [3:0]  quote_len;
		logic        last;
	} out_word_t;

endpackage

// ----- rtl/ipv4_fragment_reassembly_tracker_top.sv -----
`timescale 1ns / 1ps
// IPv4 fragment reassembly tracker.
// Input words arrive on in_valid/in_stall/in_data: a fragment descriptor or a
// time tick. Result words leave on out_valid/out_stall/out_data. Registers
// max_payload (index 0) and timeout_ms (index 1) are written over
// cfg_valid/cfg_ready/cfg_index/cfg_data. The user must write them only
// while the block is idle; the block itself does not enforce this.
// One input word is worked on at a time; in_stall is low only when idle,
// so the next word is taken at the earliest in the cycle after a result is
// loaded. A bad fragment is rejected at the first check, a too-big one or an
// end conflict at the limit check. A stored fragment passes through loading
// the ranges held before, inserting, merging and writing back the ranges; a
// full table adds an eviction scan. The range list moves through a row of
// sixteen cells over the read and write ports of the range memory.
// A tick scans for expired contexts and gives one result for each; a tick
// with nothing expired gives no result.
// A finished result sits in the output register; while out_stall is high it
// holds and the block may take the next word and work up to its result.
// Reset clears the context table, the row and the output; no clearing pass
// is needed since ranges past a context's count are never read.
`include "ipv4_fragment_reassembly_tracker_top_assert.svh"
module ipv4_fragment_reassembly_tracker_top import frt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic      cfg_index,
	input  logic [19:0] cfg_data
);

	fsm_t state_q, state_d;
	in_word_t in_q;

	logic [15:0] max_payload_q;
	logic [19:0] timeout_q;

	// context table
	logic [CTX_N-1:0] valid_q, tk_q, hf_q;
	logic [CNT_W-1:0] cnt_q   [CTX_N];
	logic [31:0]      src_q   [CTX_N];
	logic [31:0]      dst_q   [CTX_N];
	logic [15:0]      ident_q [CTX_N];
	logic [7:0]       proto_q [CTX_N];
	logic [47:0]      dl_q    [CTX_N];
	logic [15:0]      total_q [CTX_N];

	// sequencing registers
	logic [CTX_W-1:0]   slot_q, slot_d, scan_q, scan_d, best_q, best_d, tidx_q, tidx_d;
	logic [47:0]        best_dl_q, best_dl_d;
	logic               ev_q, ev_d;
	logic [CNT_W-1:0]   ld_q, ld_d, ncur_q, ncur_d;
	logic [RANGE_W-1:0] wr_q, wr_d;
	logic [CTX_N-1:0]   exp_q, exp_d;
	out_word_t          res_q, res_d;

	// output register
	out_word_t out_q;
	logic      out_valid_q;

	// range memory
	logic [31:0]      rng_mem_q [MEM_N];
	logic [31:0]      rd_data_q;
	logic             rd_vld_q;
	logic             rd_en, wr_en;
	logic [MEM_W-1:0] rd_addr, wr_addr;

	// control
	logic             create_en, drop_en, set_total_en, set_hf_en, set_cnt_en;
	logic [CTX_W-1:0] create_idx, drop_idx;
	logic             emit_en;
	out_word_t        emit_word;
	row_cmd_t         row_cmd;
	range_t           row_din, row_head;
	logic             any_ovl, any_touch;

	// derived values
	logic [15:0]      off16;
	logic [16:0]      fend17;
	logic             bad_frag;
	logic [CTX_N-1:0] match_vec, free_vec, exp_now;
	logic [CTX_W-1:0] match_idx, free_idx, exp_idx;
	logic [CTX_W-1:0] cand_idx;
	logic [47:0]      cand_dl;
	logic [CNT_W-1:0] ld_m1;
	logic [CTX_N-1:0] tbit;
	logic [3:0]       quote;
	logic             can_emit;

	function automatic out_word_t make_res(status_t st, logic [CTX_W-1:0] sl,
			logic [15:0] tot, logic ev);
		out_word_t r;
		r           = '0;
		r.status    = st;
		r.slot      = sl;
		r.reasm_len = tot;
		r.evicted   = ev;
		r.last      = 1'b1;
		return r;
	endfunction

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign can_emit  = !out_valid_q || !out_stall;

	assign off16    = {in_q.frag_offset, 3'b000};
	assign fend17   = {1'b0, off16} + {1'b0, in_q.payload_len};
	assign bad_frag = (in_q.payload_len == 16'd0) ||
		(in_q.more_frags && (in_q.payload_len[2:0] != 3'd0));
	assign ld_m1    = ld_q - 1'b1;
	assign tbit     = CTX_N'(1) << tidx_q;
	assign row_din  = '{v: 1'b1, st: rd_data_q[31:16], en: rd_data_q[15:0]};

	// key match, free slot and expiry per context
	always_comb begin
		for (int i = 0; i < CTX_N; i++) begin
			match_vec[i] = valid_q[i] && (src_q[i] == in_q.src_addr) &&
				(dst_q[i] == in_q.dst_addr) && (ident_q[i] == in_q.ident) &&
				(proto_q[i] == in_q.protocol);
			free_vec[i]  = !valid_q[i];
			exp_now[i]   = valid_q[i] && (in_q.now_ms >= dl_q[i]);
		end
	end

	// lowest set index of each vector
	always_comb begin
		match_idx = '0;
		free_idx  = '0;
		exp_idx   = '0;
		for (int i = CTX_N - 1; i >= 0; i--) begin
			if (match_vec[i]) match_idx = CTX_W'(i);
			if (free_vec[i])  free_idx  = CTX_W'(i);
			if (exp_q[i])     exp_idx   = CTX_W'(i);
		end
	end

	// eviction candidate: earlier deadline wins, lower slot on ties
	assign cand_idx = (dl_q[scan_q] < best_dl_q) ? scan_q : best_q;
	assign cand_dl  = (dl_q[scan_q] < best_dl_q) ? dl_q[scan_q] : best_dl_q;

	// time-exceeded quote from the first stored range
	always_comb begin
		quote = 4'd0;
		if (hf_q[tidx_q] && (cnt_q[tidx_q] != '0) && (rd_data_q[31:16] == 16'd0)) begin
			quote = (rd_data_q[15:0] < 16'd8) ? rd_data_q[3:0] : 4'd8;
		end
	end

	// next state and controls
	always_comb begin
		state_d      = state_q;
		slot_d       = slot_q;
		scan_d       = scan_q;
		best_d       = best_q;
		best_dl_d    = best_dl_q;
		ev_d         = ev_q;
		ld_d         = ld_q;
		ncur_d       = ncur_q;
		wr_d         = wr_q;
		exp_d        = exp_q;
		tidx_d       = tidx_q;
		res_d        = res_q;
		create_en    = 1'b0;
		create_idx   = '0;
		drop_en      = 1'b0;
		drop_idx     = slot_q;
		set_total_en = 1'b0;
		set_hf_en    = 1'b0;
		set_cnt_en   = 1'b0;
		rd_en        = 1'b0;
		rd_addr      = '0;
		wr_en        = 1'b0;
		wr_addr      = {slot_q, wr_q};
		emit_en      = 1'b0;
		emit_word    = res_q;
		row_cmd      = '{op: ROW_HOLD, lo: off16, hi: fend17[15:0]};
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = (in_data.action == ACT_TICK) ? S_TSCAN : S_FRAG;
				end
			end
			S_FRAG: begin
				if (bad_frag) begin
					res_d   = make_res(ST_BAD, '0, 16'd0, 1'b0);
					state_d = S_EMIT;
				end else if (|match_vec) begin
					slot_d  = match_idx;
					ev_d    = 1'b0;
					state_d = S_LIMIT;
				end else if (|free_vec) begin
					create_en  = 1'b1;
					create_idx = free_idx;
					slot_d     = free_idx;
					ev_d       = 1'b0;
					state_d    = S_LIMIT;
				end else begin
					scan_d    = CTX_W'(1);
					best_d    = '0;
					best_dl_d = dl_q[0];
					state_d   = S_EVICT;
				end
			end
			S_EVICT: begin
				if (scan_q == CTX_W'(CTX_N - 1)) begin
					create_en  = 1'b1;
					create_idx = cand_idx;
					slot_d     = cand_idx;
					ev_d       = 1'b1;
					state_d    = S_LIMIT;
				end else begin
					best_d    = cand_idx;
					best_dl_d = cand_dl;
					scan_d    = scan_q + 1'b1;
				end
			end
			S_LIMIT: begin
				if (fend17 > {1'b0, max_payload_q}) begin
					drop_en = 1'b1;
					res_d   = make_res(ST_TOO_BIG, slot_q, 16'd0, ev_q);
					state_d = S_EMIT;
				end else if (!in_q.more_frags && tk_q[slot_q] &&
						(total_q[slot_q] != fend17[15:0])) begin
					drop_en = 1'b1;
					res_d   = make_res(ST_CONFLICT, slot_q, 16'd0, ev_q);
					state_d = S_EMIT;
				end else if (in_q.more_frags && tk_q[slot_q] &&
						(fend17 > {1'b0, total_q[slot_q]})) begin
					drop_en = 1'b1;
					res_d   = make_res(ST_CONFLICT, slot_q, 16'd0, ev_q);
					state_d = S_EMIT;
				end else begin
					set_total_en = !in_q.more_frags;
					ld_d         = cnt_q[slot_q];
					row_cmd.op   = ROW_CLEAR;
					state_d      = S_LOAD;
				end
			end
			S_LOAD: begin
				// read the list last entry first; each word shifts in at the head
				if (rd_vld_q) row_cmd.op = ROW_LOAD;
				if (ld_q != '0) begin
					rd_en   = 1'b1;
					rd_addr = {slot_q, ld_m1[RANGE_W-1:0]};
					ld_d    = ld_m1;
				end else if (!rd_vld_q) begin
					state_d = S_INSERT;
				end
			end
			S_INSERT: begin
				if (any_ovl || (cnt_q[slot_q] == CNT_W'(RANGE_N))) begin
					drop_en = 1'b1;
					res_d   = make_res(ST_CONFLICT, slot_q, 16'd0, ev_q);
					state_d = S_EMIT;
				end else begin
					row_cmd.op = ROW_INSERT;
					ncur_d     = cnt_q[slot_q] + 1'b1;
					state_d    = S_MERGE;
				end
			end
			S_MERGE: begin
				if (any_touch) begin
					row_cmd.op = ROW_MERGE;
					ncur_d     = ncur_q - 1'b1;
				end else if ((hf_q[slot_q] || (off16 == 16'd0)) && tk_q[slot_q] &&
						(ncur_q == CNT_W'(1)) && (row_head.st == 16'd0) &&
						(row_head.en == total_q[slot_q])) begin
					drop_en = 1'b1;
					res_d   = make_res(ST_COMPLETE, slot_q, total_q[slot_q], ev_q);
					state_d = S_EMIT;
				end else begin
					set_hf_en  = (off16 == 16'd0);
					set_cnt_en = 1'b1;
					wr_d       = '0;
					state_d    = S_STORE;
				end
			end
			S_STORE: begin
				// write the head cell, then shift the row toward it
				wr_en      = 1'b1;
				row_cmd.op = ROW_STORE;
				wr_d       = wr_q + 1'b1;
				if (CNT_W'(wr_q) == (ncur_q - 1'b1)) begin
					res_d   = make_res(ST_STORED, slot_q, 16'd0, ev_q);
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (can_emit) begin
					emit_en = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_TSCAN: begin
				exp_d   = exp_now;
				state_d = S_TNEXT;
			end
			S_TNEXT: begin
				if (exp_q == '0) begin
					state_d = S_IDLE;
				end else begin
					tidx_d  = exp_idx;
					rd_en   = 1'b1;
					rd_addr = {exp_idx, RANGE_W'(0)};
					state_d = S_TEMIT;
				end
			end
			S_TEMIT: begin
				if (can_emit) begin
					emit_en                      = 1'b1;
					emit_word                    = '0;
					emit_word.status             = ST_TIMEOUT;
					emit_word.slot               = tidx_q;
					emit_word.send_time_exceeded = hf_q[tidx_q];
					emit_word.quote_len          = quote;
					emit_word.last               = ((exp_q & ~tbit) == '0);
					drop_en                      = 1'b1;
					drop_idx                     = tidx_q;
					exp_d                        = exp_q & ~tbit;
					state_d                      = S_TNEXT;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q    <= '0;
			scan_q    <= '0;
			best_q    <= '0;
			best_dl_q <= '0;
			ev_q      <= 1'b0;
			ld_q      <= '0;
			ncur_q    <= '0;
			wr_q      <= '0;
			exp_q     <= '0;
			tidx_q    <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			slot_q    <= slot_d;
			scan_q    <= scan_d;
			best_q    <= best_d;
			best_dl_q <= best_dl_d;
			ev_q      <= ev_d;
			ld_q      <= ld_d;
			ncur_q    <= ncur_d;
			wr_q      <= wr_d;
			exp_q     <= exp_d;
			tidx_q    <= tidx_d;
			rd_vld_q  <= rd_en;
		end
	end

	// capture the accepted word and the pending result
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) in_q <= in_data;
		res_q <= res_d;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= 16'd65535;
			timeout_q     <= 20'd30000;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MAX_PAYLOAD: max_payload_q <= cfg_data[15:0];
				REG_TIMEOUT:     timeout_q     <= cfg_data;
				default:         ;
			endcase
		end
	end

	// context flags and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			tk_q    <= '0;
			hf_q    <= '0;
			for (int i = 0; i < CTX_N; i++) cnt_q[i] <= '0;
		end else begin
			if (create_en) begin
				valid_q[create_idx] <= 1'b1;
				tk_q[create_idx]    <= 1'b0;
				hf_q[create_idx]    <= 1'b0;
				cnt_q[create_idx]   <= '0;
			end
			if (drop_en) begin
				valid_q[drop_idx] <= 1'b0;
				tk_q[drop_idx]    <= 1'b0;
				hf_q[drop_idx]    <= 1'b0;
				cnt_q[drop_idx]   <= '0;
			end
			if (set_total_en) tk_q[slot_q] <= 1'b1;
			if (set_hf_en) hf_q[slot_q] <= 1'b1;
			if (set_cnt_en) cnt_q[slot_q] <= ncur_q;
		end
	end

	// context keys, deadline and pinned length
	always_ff @(posedge clk) begin
		if (create_en) begin
			src_q[create_idx]   <= in_q.src_addr;
			dst_q[create_idx]   <= in_q.dst_addr;
			ident_q[create_idx] <= in_q.ident;
			proto_q[create_idx] <= in_q.protocol;
			dl_q[create_idx]    <= in_q.now_ms + 48'(timeout_q);
		end
		if (set_total_en) total_q[slot_q] <= fend17[15:0];
	end

	// range memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (wr_en) rng_mem_q[wr_addr] <= {row_head.st, row_head.en};
		if (rd_en) rd_data_q <= rng_mem_q[rd_addr];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_en) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_en) out_q <= emit_word;
	end

	frt_range_row u_row (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (row_cmd),
		.din       (row_din),
		.head      (row_head),
		.any_ovl   (any_ovl),
		.any_touch (any_touch)
	);

	`FRT_ASSERT_ALWAYS(a_ncur_cap, ncur_q <= CNT_W'(RANGE_N), "range count past capacity")
	`FRT_ASSERT_IMPLY(a_complete_len, out_valid_q && (out_q.status == ST_COMPLETE), out_q.reasm_len != 16'd0, "zero complete length")
	`FRT_ASSERT_IMPLY(a_tick_pick, state_q == S_TEMIT, exp_q[tidx_q], "timeout word for a context not expired")

endmodule

// ----- rtl/frt_range_cell.sv -----
`timescale 1ns / 1ps
module frt_range_cell import frt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  row_cmd_t cmd,
	input  range_t   left_rng,
	input  logic     left_gt,
	input  range_t   right_rng,
	input  logic     merge_in,
	output range_t   rng,
	output logic     gt,
	output logic     merge_out,
	output logic     ovl
);

	logic        v_q;
	logic [15:0] st_q;
	logic [15:0] en_q;
	logic        touch;
	range_t      cur;
	range_t      nxt;

	assign cur = '{v: v_q, st: st_q, en: en_q};
	assign rng = cur;

	// compare this range against the new one and the right neighbor
	assign gt        = v_q && !(cmd.hi <= st_q);
	assign ovl       = v_q && (cmd.lo < en_q) && (st_q < cmd.hi);
	assign touch     = v_q && right_rng.v && (en_q == right_rng.st);
	assign merge_out = merge_in || touch;

	// pick next contents from self or a neighbor
	always_comb begin
		nxt = cur;
		case (cmd.op)
			ROW_CLEAR: nxt.v = 1'b0;
			ROW_LOAD:  nxt = left_rng;
			ROW_STORE: nxt = right_rng;
			ROW_INSERT: begin
				if (gt) begin
					nxt = cur;
				end else if (left_gt) begin
					nxt = '{v: 1'b1, st: cmd.lo, en: cmd.hi};
				end else begin
					nxt = left_rng;
				end
			end
			ROW_MERGE: begin
				if (merge_in) begin
					nxt = right_rng;
				end else if (touch) begin
					nxt.en = right_rng.en;
				end
			end
			default: nxt = cur;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= nxt.v;
		end
	end

	always_ff @(posedge clk) begin
		st_q <= nxt.st;
		en_q <= nxt.en;
	end

endmodule

// ----- rtl/frt_range_row.sv -----
`timescale 1ns / 1ps
module frt_range_row import frt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  row_cmd_t cmd,
	input  range_t   din,
	output range_t   head,
	output logic     any_ovl,
	output logic     any_touch
);

	range_t               rngs [RANGE_N];
	logic [RANGE_N-1:0]   gts;
	logic [RANGE_N-1:0]   ovls;
	logic [RANGE_N:0]     merge_chain;

	assign merge_chain[0] = 1'b0;

	// sorted row of range cells, each talking to its neighbors
	for (genvar i = 0; i < RANGE_N; i++) begin : g_cell
		range_t left_rng;
		range_t right_rng;
		logic   left_gt;

		if (i == 0) begin : g_first
			assign left_rng = '{v: 1'b1, st: din.st, en: din.en};
			assign left_gt  = 1'b1;
		end else begin : g_mid
			assign left_rng = rngs[i-1];
			assign left_gt  = gts[i-1];
		end

		if (i == RANGE_N - 1) begin : g_tail
			assign right_rng = '0;
		end else begin : g_inner
			assign right_rng = rngs[i+1];
		end

		frt_range_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.left_rng  (left_rng),
			.left_gt   (left_gt),
			.right_rng (right_rng),
			.merge_in  (merge_chain[i]),
			.rng       (rngs[i]),
			.gt        (gts[i]),
			.merge_out (merge_chain[i+1]),
			.ovl       (ovls[i])
		);
	end

	assign head      = rngs[0];
	assign any_ovl   = |ovls;
	assign any_touch = merge_chain[RANGE_N];

endmodule

// ----- bench/frt_checker.sv -----
`timescale 1ns / 1ps
module frt_checker import frt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_stall,
	input  in_word_t  in_data,
	input  logic      out_valid,
	input  logic      out_stall,
	input  out_word_t out_data,
	input  logic      cfg_valid,
	input  logic      cfg_ready,
	input  logic      cfg_index,
	input  logic [19:0] cfg_data,
	output int        errors,
	output int        pending
);

	// tracker copy of the block state
	logic [15:0] lim_payload;
	logic [19:0] lim_timeout;
	logic        c_valid [CTX_N];
	logic [31:0] c_src [CTX_N];
	logic [31:0] c_dst [CTX_N];
	logic [15:0] c_id [CTX_N];
	logic [7:0]  c_proto [CTX_N];
	logic [47:0] c_dl [CTX_N];
	logic        c_tknown [CTX_N];
	logic [16:0] c_total [CTX_N];
	logic        c_first [CTX_N];
	int          c_cnt [CTX_N];
	int          r_lo [CTX_N][RANGE_N+1];
	int          r_hi [CTX_N][RANGE_N+1];

	out_word_t result_q [$];

	function automatic out_word_t mk(status_t st, int s, int tot, bit ev, bit ste, int q);
		out_word_t w;
		w = '0;
		w.status = st;
		w.slot = s[2:0];
		w.reasm_len = tot[15:0];
		w.evicted = ev;
		w.send_time_exceeded = ste;
		w.quote_len = q[3:0];
		w.last = 1'b1;
		return w;
	endfunction

	function automatic void release_ctx(int s);
		c_valid[s] = 0;
		c_tknown[s] = 0;
		c_first[s] = 0;
		c_cnt[s] = 0;
	endfunction

	// insert a byte range, merge neighbours; 0 on overlap or full list
	function automatic bit insert_range(int s, int lo, int hi);
		int n, pos;
		n = c_cnt[s];
		pos = n;
		for (int i = 0; i < n; i++) begin
			if (lo < r_hi[s][i] && r_lo[s][i] < hi) return 0;
			if (hi <= r_lo[s][i]) begin
				pos = i;
				break;
			end
		end
		if (n >= RANGE_N) return 0;
		for (int j = n; j > pos; j--) begin
			r_lo[s][j] = r_lo[s][j-1];
			r_hi[s][j] = r_hi[s][j-1];
		end
		r_lo[s][pos] = lo;
		r_hi[s][pos] = hi;
		n++;
		for (int k = n - 2; k >= 0; k--) begin
			if (r_hi[s][k] == r_lo[s][k+1]) begin
				r_hi[s][k] = r_hi[s][k+1];
				for (int j = k + 1; j + 1 < n; j++) begin
					r_lo[s][j] = r_lo[s][j+1];
					r_hi[s][j] = r_hi[s][j+1];
				end
				n--;
			end
		end
		c_cnt[s] = n;
		return 1;
	endfunction

	task automatic predict_word(in_word_t w);
		int s, off, fend, q, lastk;
		bit ev;
		out_word_t r;
		if (w.action == ACT_TICK) begin
			lastk = -1;
			for (int i = 0; i < CTX_N; i++) begin
				if (!c_valid[i] || w.now_ms < c_dl[i]) continue;
				q = 0;
				if (c_first[i] && c_cnt[i] > 0 && r_lo[i][0] == 0)
					q = r_hi[i][0] < 8 ? r_hi[i][0] : 8;
				r = mk(ST_TIMEOUT, i, 0, 0, c_first[i], q);
				r.last = 0;
				result_q.push_back(r);
				lastk = result_q.size() - 1;
				release_ctx(i);
			end
			if (lastk >= 0) result_q[lastk].last = 1;
			return;
		end
		off = int'(w.frag_offset) * 8;
		fend = off + int'(w.payload_len);
		ev = 0;
		if (w.payload_len == 0 || (w.more_frags && w.payload_len[2:0] != 0)) begin
			result_q.push_back(mk(ST_BAD, 0, 0, 0, 0, 0));
			return;
		end
		s = CTX_N;
		for (int i = 0; i < CTX_N; i++)
			if (c_valid[i] && c_src[i] == w.src_addr && c_dst[i] == w.dst_addr &&
			    c_id[i] == w.ident && c_proto[i] == w.protocol) begin
				s = i;
				break;
			end
		if (s == CTX_N) begin
			for (int i = 0; i < CTX_N; i++)
				if (!c_valid[i]) begin
					s = i;
					break;
				end
			if (s == CTX_N) begin
				s = 0;
				for (int i = 1; i < CTX_N; i++)
					if (c_dl[i] < c_dl[s]) s = i;
				ev = 1;
			end
			release_ctx(s);
			c_valid[s] = 1;
			c_src[s] = w.src_addr;
			c_dst[s] = w.dst_addr;
			c_id[s] = w.ident;
			c_proto[s] = w.protocol;
			c_dl[s] = w.now_ms + 48'(lim_timeout);
		end
		if (fend > int'(lim_payload)) begin
			release_ctx(s);
			result_q.push_back(mk(ST_TOO_BIG, s, 0, ev, 0, 0));
			return;
		end
		if (!w.more_frags) begin
			if (c_tknown[s] && int'(c_total[s]) != fend) begin
				release_ctx(s);
				result_q.push_back(mk(ST_CONFLICT, s, 0, ev, 0, 0));
				return;
			end
			c_total[s] = fend;
			c_tknown[s] = 1;
		end
		if ((c_tknown[s] && fend > int'(c_total[s])) || !insert_range(s, off, fend)) begin
			release_ctx(s);
			result_q.push_back(mk(ST_CONFLICT, s, 0, ev, 0, 0));
			return;
		end
		if (off == 0) c_first[s] = 1;
		if (c_first[s] && c_tknown[s] && c_cnt[s] == 1 && r_lo[s][0] == 0 &&
		    r_hi[s][0] == int'(c_total[s])) begin
			q = c_total[s];
			release_ctx(s);
			result_q.push_back(mk(ST_COMPLETE, s, q, ev, 0, 0));
			return;
		end
		result_q.push_back(mk(ST_STORED, s, 0, ev, 0, 0));
	endtask

	// watch handshakes, predict and compare
	always @(posedge clk or negedge arst_n) begin
		out_word_t exp_w;
		if (!arst_n) begin
			errors <= 0;
			lim_payload = 16'hFFFF;
			lim_timeout = 20'd30000;
			for (int i = 0; i < CTX_N; i++) begin
				c_valid[i] = 0;
				c_dl[i] = '0;
				release_ctx(i);
			end
			result_q.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_reg_t'(cfg_index) == REG_MAX_PAYLOAD) lim_payload = cfg_data[15:0];
				else lim_timeout = cfg_data;
			end
			if (out_valid && !out_stall) begin
				if (result_q.size() == 0) begin
					if (errors < 10) $display("unexpected result word %p", out_data);
					errors <= errors + 1;
				end else begin
					exp_w = result_q.pop_front();
					if (exp_w !== out_data) begin
						if (errors < 10)
							$display("result mismatch: expected %p got %p", exp_w, out_data);
						errors <= errors + 1;
					end
				end
			end
			if (in_valid && !in_stall) predict_word(in_data);
			pending <= result_q.size();
		end
	end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
module tb import frt_pkg::*;;

	localparam int WATCHDOG = 20000;

	logic      clk = 0;
	logic      arst_n = 0;
	logic      in_valid = 0;
	logic      in_stall;
	in_word_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 0;
	out_word_t out_data;
	logic      cfg_valid = 0;
	logic      cfg_ready;
	logic      cfg_index = 0;
	logic [19:0] cfg_data = '0;
	int        errors;
	int        pending;
	int        quiet_cycles = 0;
	bit        calm = 0;
	logic [47:0] clock_ms = 48'd1000;
	logic [31:0] flow_src [4];
	logic [15:0] flow_id [4];

	ipv4_fragment_reassembly_tracker_top i_dut (.*);

	frt_checker i_chk (.*);

	always #6 clk = ~clk;

	// stall the result side at random, except in the calm stretch
	always @(posedge clk) out_stall <= calm ? 1'b0 : ($urandom_range(99) < 21);

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WATCHDOG) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// the block is busy after each word, so the first wait costs no
	// throughput and lets valid drop between words
	task automatic send(in_word_t w);
		@(posedge clk);
		while (!calm && $urandom_range(99) < 21) @(posedge clk);
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (in_stall);
		in_valid <= 1'b0;
	endtask

	task automatic drain();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [19:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic in_word_t frag(int f, int off, bit mf, int len);
		in_word_t w;
		w = '0;
		w.action = ACT_FRAG;
		w.src_addr = flow_src[f];
		w.dst_addr = ~flow_src[f];
		w.ident = flow_id[f];
		w.protocol = 8'd17;
		w.frag_offset = off[12:0];
		w.more_frags = mf;
		w.payload_len = len[15:0];
		w.now_ms = clock_ms;
		return w;
	endfunction

	function automatic in_word_t tick(logic [47:0] t);
		in_word_t w;
		w = '0;
		w.action = ACT_TICK;
		w.now_ms = t;
		return w;
	endfunction

	function automatic in_word_t noise();
		in_word_t w;
		logic [191:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		w = raw[$bits(in_word_t)-1:0];
		w.action = ACT_FRAG;
		w.has_header_zero = 1'b0;
		if ($urandom_range(1)) w.payload_len[15:10] = '0;
		return w;
	endfunction

	task automatic send_datagram(int f, int pieces);
		int off, len;
		off = 0;
		for (int p = 0; p < pieces; p++) begin
			len = 8 * $urandom_range(1, 6);
			if (p == pieces - 1) len = len - $urandom_range(0, 7);
			if ($urandom_range(15) == 0) off = off - 1;
			send(frag(f, off, p != pieces - 1, len));
			off = off + (len + 7) / 8 + ($urandom_range(5) == 0 ? 1 : 0);
			clock_ms = clock_ms + $urandom_range(0, 3);
		end
	endtask

	initial begin
		logic [47:0] t;
		for (int f = 0; f < 4; f++) begin
			flow_src[f] = $urandom;
			flow_id[f] = 16'($urandom);
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: bad words, edges, overlap, too big, end conflict, eviction, ticks
		write_reg(REG_TIMEOUT, 20'd50);
		send(frag(0, 0, 1, 0));
		send(frag(0, 0, 1, 12));
		send(frag(0, 8191, 0, 65535));
		send(frag(0, 0, 1, 16));
		send(frag(0, 1, 1, 8));
		send(frag(0, 3, 0, 5));
		send(frag(1, 0, 1, 16));
		send(frag(1, 0, 1, 16));
		send(frag(2, 4, 0, 8));
		send(frag(2, 4, 0, 9));
		send(frag(3, 2, 1, 8));
		send(frag(3, 2, 0, 10));
		send(frag(3, 0, 1, 3 * 8));
		for (int g = 0; g < 9; g++) begin
			in_word_t w;
			w = frag(0, 0, 1, 8);
			w.ident = 16'hFF00 + 16'(g);
			w.src_addr = g[0] ? 32'hFFFF_FFFF : 32'h0;
			w.dst_addr = g[1] ? 32'hFFFF_FFFF : 32'h0;
			w.protocol = g[2] ? 8'hFF : 8'h0;
			w.now_ms = clock_ms + 48'(g);
			send(w);
		end
		send(tick(clock_ms + 49));
		send(tick(48'hFFFF_FFFF_FFFF));
		drain();

		// directed: range list overflow and deadline wrap
		write_reg(REG_TIMEOUT, 20'd1);
		for (int p = 0; p < 17; p++) send(frag(1, 2 * p, 1, 8));
		clock_ms = 48'hFFFF_FFFF_FFFF;
		send(frag(2, 0, 1, 8));
		send(tick(48'd0));
		clock_ms = 48'd5000;
		drain();

		write_reg(REG_MAX_PAYLOAD, 20'd8);
		write_reg(REG_TIMEOUT, 20'd600000);
		send(frag(0, 0, 0, 8));
		send(frag(0, 0, 0, 9));
		send(frag(0, 1, 0, 1));
		drain();

		// random phases over several settings
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin write_reg(REG_MAX_PAYLOAD, 20'd200); write_reg(REG_TIMEOUT, 20'd20); end
				1: begin write_reg(REG_MAX_PAYLOAD, 20'hFFFF); write_reg(REG_TIMEOUT, 20'd1); end
				2: begin write_reg(REG_MAX_PAYLOAD, 20'd100); write_reg(REG_TIMEOUT, 20'd30000); end
				default: begin
					write_reg(REG_MAX_PAYLOAD, 20'd1000);
					write_reg(REG_TIMEOUT, 20'd10);
				end
			endcase
			calm = (ph == 2);
			for (int k = 0; k < 45; ) begin
				case ($urandom_range(9))
					0: begin send(noise()); k++; end
					1: begin
						clock_ms = clock_ms + $urandom_range(0, 30);
						send(tick(clock_ms));
						k++;
					end
					default: begin
						int n;
						n = $urandom_range(1, 5);
						flow_id[$urandom_range(3)] = 16'($urandom);
						send_datagram($urandom_range(3), n);
						k += n;
					end
				endcase
			end
			t = clock_ms + 48'd700000;
			send(tick(t));
			clock_ms = t + 1;
			drain();
		end

		// wait out the tail, then give the verdict
		drain();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- ipv4_fragment_reassembly_tracker_top.f -----
+incdir+rtl
rtl/frt_pkg.sv
rtl/frt_range_cell.sv
rtl/frt_range_row.sv
rtl/ipv4_fragment_reassembly_tracker_top.sv
bench/frt_checker.sv
bench/tb.sv
